// ----- hdl/b2h_pkg.sv -----
`default_nettype none
package b2h_pkg;

    localparam int PHASE_BITS = 32;
    localparam int SCALE_BITS = 32;
    localparam int BIN_BITS   = 7;
    localparam int DISP_BITS  = 11;
    localparam int COORD_BITS = 10;
    localparam int CELL_BITS  = 16;
    localparam int CFG_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int ACT_BITS   = 2;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_ACCUM = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_SCALE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_SIZE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISP_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISP_HEIGHT = 2'd3;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'd333772;
    localparam logic [BIN_BITS-1:0]   BIN_RESET   = 7'd1;
    localparam logic [DISP_BITS-1:0]  DISP_RESET  = 11'd1024;

endpackage
`default_nettype wire

// ----- hdl/binned_2d_histogram_accumulator.sv -----
`default_nettype none
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------------
// in       | input     | i_in_valid / o_in_ready    | action, phases, mask, flags, read xy
// out      | output    | o_out_valid / i_out_ready  | cell_count, accepted, oor, bounds
// cfg      | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// accumulate: scale, range check, bin remainder one coordinate bit at a time, bin check,
//   read-modify-write of bin_size^2 cells, drain, result; the read-modify-write of the
//   histogram memory retires one cell per cycle. read: address, data, result. dropped
//   pixel: straight to the result. the block returns to idle to take the next transaction
// reset and clear: a sweep writes zero to every memory entry, one per cycle
//   (2^(clog2(HIST_W)+clog2(HIST_H)) entries, 1048576 at default), no transaction taken
// the output register decouples stalls: a new transaction is taken while a result waits
module binned_2d_histogram_accumulator
    import b2h_pkg::*;
#(
    parameter int HIST_W     = 1024,
    parameter int HIST_H     = 1024,
    parameter int COUNT_BITS = 16,
    parameter int MAX_BIN    = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [ACT_BITS-1:0]     i_action,
    input  wire logic signed [PHASE_BITS-1:0] i_phase_x,
    input  wire logic signed [PHASE_BITS-1:0] i_phase_y,
    input  wire logic                    i_pixel_mask,
    input  wire logic                    i_x_valid,
    input  wire logic                    i_y_valid,
    input  wire logic [COORD_BITS-1:0]   i_read_x,
    input  wire logic [COORD_BITS-1:0]   i_read_y,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [CELL_BITS-1:0]         o_cell_count,
    output logic                         o_accepted,
    output logic                         o_out_of_range,
    output logic [COORD_BITS-1:0]        o_min_x,
    output logic [COORD_BITS-1:0]        o_max_x,
    output logic [COORD_BITS-1:0]        o_min_y,
    output logic [COORD_BITS-1:0]        o_max_y
);

    localparam int XW = $clog2(HIST_W);
    localparam int YW = $clog2(HIST_H);
    localparam int AW = XW + YW;
    localparam int CW = (XW > YW) ? XW : YW;
    localparam int SW = $clog2(CW);
    localparam int LW = ((CW > DISP_BITS) ? CW : DISP_BITS) + 2;
    localparam int RW = COORD_BITS + 3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_PREP, S_DIV, S_CHECK, S_RMW, S_DRAIN,
        S_READ, S_RDATA, S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [SCALE_BITS-1:0] r_scale;
    logic [BIN_BITS-1:0]   r_bin;
    logic [DISP_BITS-1:0]  r_dw;
    logic [DISP_BITS-1:0]  r_dh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_bin   <= BIN_RESET;
            r_dw    <= DISP_RESET;
            r_dh    <= DISP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PHASE_SCALE: r_scale <= i_cfg_data;
                CFG_BIN_SIZE:    r_bin   <= i_cfg_data[BIN_BITS-1:0];
                CFG_DISP_WIDTH:  r_dw    <= i_cfg_data[DISP_BITS-1:0];
                CFG_DISP_HEIGHT: r_dh    <= i_cfg_data[DISP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective bin and display size
    logic [BIN_BITS-1:0] bin_c;
    logic [LW-1:0]       wc;
    logic [LW-1:0]       hc;

    always_comb begin
        if (r_bin == '0) begin
            bin_c = BIN_BITS'(1);
        end else if ({2'b00, r_bin} > (BIN_BITS+2)'(MAX_BIN)) begin
            bin_c = BIN_BITS'(MAX_BIN);
        end else begin
            bin_c = r_bin;
        end
        wc = (LW'(r_dw) > LW'(HIST_W)) ? LW'(HIST_W) : LW'(r_dw);
        hc = (LW'(r_dh) > LW'(HIST_H)) ? LW'(HIST_H) : LW'(r_dh);
    end

    // transaction payload and work registers
    logic [PHASE_BITS-1:0] r_px;
    logic [PHASE_BITS-1:0] r_py;
    logic [XW-1:0]         r_rx;
    logic [YW-1:0]         r_ry;
    logic                  r_rd_ok;
    logic [PHASE_BITS-1:0] r_vx;
    logic [PHASE_BITS-1:0] r_vy;
    logic [BIN_BITS-1:0]   r_remx;
    logic [BIN_BITS-1:0]   r_remy;
    logic [SW-1:0]         r_step;
    logic [CW-1:0]         r_cx;
    logic [CW-1:0]         r_cy;
    logic [BIN_BITS-1:0]   r_i;
    logic [BIN_BITS-1:0]   r_j;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_clr_reply;
    logic                  r_wb_pend;
    logic [AW-1:0]         r_wb_addr;
    logic [COUNT_BITS-1:0] r_rdata;

    // running bounds
    logic [XW-1:0] r_lo_x;
    logic [XW-1:0] r_hi_x;
    logic [YW-1:0] r_lo_y;
    logic [YW-1:0] r_hi_y;

    // per-transaction result
    logic [COUNT_BITS-1:0] r_res_cnt;
    logic                  r_res_acc;
    logic                  r_res_oor;

    // output register
    logic                  r_out_valid;
    logic [CELL_BITS-1:0]  r_o_cnt;
    logic                  r_o_acc;
    logic                  r_o_oor;
    logic [COORD_BITS-1:0] r_o_min_x;
    logic [COORD_BITS-1:0] r_o_max_x;
    logic [COORD_BITS-1:0] r_o_min_y;
    logic [COORD_BITS-1:0] r_o_max_y;

    // scaling: two 32x32 products, integer part only
    logic [2*PHASE_BITS-1:0] prod_x;
    logic [2*PHASE_BITS-1:0] prod_y;
    assign prod_x = r_px * r_scale;
    assign prod_y = r_py * r_scale;

    // one restoring remainder step per cycle for each coordinate
    logic [BIN_BITS:0]   shx;
    logic [BIN_BITS:0]   shy;
    logic [BIN_BITS-1:0] n_remx;
    logic [BIN_BITS-1:0] n_remy;
    logic [CW-1:0]       vx_n;
    logic [CW-1:0]       vy_n;

    always_comb begin
        vx_n = CW'(r_vx);
        vy_n = CW'(r_vy);
        shx  = {r_remx, vx_n[r_step]};
        shy  = {r_remy, vy_n[r_step]};
        n_remx = (shx >= {1'b0, bin_c}) ? BIN_BITS'(shx - {1'b0, bin_c}) : BIN_BITS'(shx);
        n_remy = (shy >= {1'b0, bin_c}) ? BIN_BITS'(shy - {1'b0, bin_c}) : BIN_BITS'(shy);
    end

    // snapped bin origin and fit check
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic          bin_fits;

    always_comb begin
        cx = vx_n - CW'(r_remx);
        cy = vy_n - CW'(r_remy);
        bin_fits = (LW'(cx) + LW'(bin_c) <= wc) && (LW'(cy) + LW'(bin_c) <= hc);
    end

    // histogram memory ports
    logic [AW-1:0]         rmw_addr;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic                  last_cell;

    always_comb begin
        rmw_addr  = {YW'(r_cy + CW'(r_j)), XW'(r_cx + CW'(r_i))};
        rd_addr   = (r_state == S_READ) ? {r_ry, r_rx} : rmw_addr;
        last_cell = (r_i == bin_c - 1'b1) && (r_j == bin_c - 1'b1);
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            // saturating increment of the cell read in the cycle before
            mem_we = r_wb_pend;
            mem_wa = r_wb_addr;
            mem_wd = (&r_rdata) ? r_rdata : r_rdata + 1'b1;
        end
    end

    logic [COUNT_BITS-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_wb_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_lo_x      <= XW'(HIST_W - 1);
            r_hi_x      <= '0;
            r_lo_y      <= YW'(HIST_H - 1);
            r_hi_y      <= '0;
        end else begin
            // result taken and no new one ready this cycle
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            // write-back follows every read-modify-write issue cycle
            r_wb_pend <= (r_state == S_RMW);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= r_clr_reply ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_px      <= i_phase_x[PHASE_BITS-1] ? '0 : i_phase_x;
                        r_py      <= i_phase_y[PHASE_BITS-1] ? '0 : i_phase_y;
                        r_rx      <= XW'(i_read_x);
                        r_ry      <= YW'(i_read_y);
                        r_rd_ok   <= (RW'(i_read_x) < RW'(HIST_W)) &&
                                     (RW'(i_read_y) < RW'(HIST_H));
                        r_res_cnt <= '0;
                        r_res_acc <= 1'b0;
                        r_res_oor <= 1'b0;
                        unique case (i_action)
                            ACT_ACCUM: begin
                                if (i_pixel_mask && i_x_valid && i_y_valid) begin
                                    r_state <= S_MUL;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            ACT_READ: r_state <= S_READ;
                            ACT_CLEAR: begin
                                r_lo_x      <= XW'(HIST_W - 1);
                                r_hi_x      <= '0;
                                r_lo_y      <= YW'(HIST_H - 1);
                                r_hi_y      <= '0;
                                r_clr_addr  <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_MUL: begin
                    r_vx    <= prod_x[2*PHASE_BITS-1:PHASE_BITS];
                    r_vy    <= prod_y[2*PHASE_BITS-1:PHASE_BITS];
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    // a coordinate at or past the display edge can never fit
                    if (r_vx >= PHASE_BITS'(wc) || r_vy >= PHASE_BITS'(hc)) begin
                        r_res_oor <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_remx  <= '0;
                        r_remy  <= '0;
                        r_step  <= SW'(CW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_remx <= n_remx;
                    r_remy <= n_remy;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_cx <= cx;
                    r_cy <= cy;
                    r_i  <= '0;
                    r_j  <= '0;
                    if (bin_fits) begin
                        if (XW'(cx) > r_hi_x) r_hi_x <= XW'(cx);
                        if (XW'(cx) < r_lo_x) r_lo_x <= XW'(cx);
                        if (YW'(cy) > r_hi_y) r_hi_y <= YW'(cy);
                        if (YW'(cy) < r_lo_y) r_lo_y <= YW'(cy);
                        r_res_acc <= 1'b1;
                        r_state   <= S_RMW;
                    end else begin
                        r_res_oor <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_RMW: begin
                    // read this cell now, write it back next cycle
                    r_wb_addr <= rmw_addr;
                    if (r_i == bin_c - 1'b1) begin
                        r_i <= '0;
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                    if (last_cell) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_DONE;
                S_READ:  r_state <= S_RDATA;
                S_RDATA: begin
                    r_res_cnt <= r_rd_ok ? r_rdata : '0;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_cnt     <= CELL_BITS'(r_res_cnt);
                        r_o_acc     <= r_res_acc;
                        r_o_oor     <= r_res_oor;
                        r_o_min_x   <= COORD_BITS'(r_lo_x);
                        r_o_max_x   <= COORD_BITS'(r_hi_x);
                        r_o_min_y   <= COORD_BITS'(r_lo_y);
                        r_o_max_y   <= COORD_BITS'(r_hi_y);
                        r_clr_reply <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cell_count   = r_o_cnt;
    assign o_accepted     = r_o_acc;
    assign o_out_of_range = r_o_oor;
    assign o_min_x        = r_o_min_x;
    assign o_max_x        = r_o_max_x;
    assign o_min_y        = r_o_min_y;
    assign o_max_y        = r_o_max_y;

    // no histogram write while waiting for a transaction
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("histogram written while idle");

    // a result is either counted or out of range, never both
    a_acc_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_out_of_range))
        else $error("accepted and out of range together");

    // once a pixel is counted the bounds are ordered
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_min_x <= o_max_x && o_min_y <= o_max_y))
        else $error("bounds out of order after accepted pixel");

    // write-back only directly after a read-modify-write issue
    a_wb_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_pend |-> ($past(r_state) == S_RMW))
        else $error("write-back without issue");

endmodule
`default_nettype wire
